>>> rtl/core/cramer_linear_solver_unit_defines.svh
// Assertion macros shared by the solver RTL.
`ifndef CRAMER_LINEAR_SOLVER_UNIT_DEFINES_SVH
`define CRAMER_LINEAR_SOLVER_UNIT_DEFINES_SVH

// Same-cycle implication under reset.
`define CRLS_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("solver assertion failed");

// Next-cycle implication under reset.
`define CRLS_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("solver assertion failed");

`endif

>>> rtl/core/crls_pkg.sv
// Shared types for the Cramer's rule solver.
package crls_pkg;

    typedef enum logic [3:0] {
        S_LOAD,
        S_TUP,
        S_RD,
        S_OP,
        S_MUL,
        S_ACC,
        S_DET_END,
        S_DIV,
        S_EMIT,
        S_NOSOL
    } state_t;

    localparam int unsigned SOL_WIDTH = 32;
    localparam int unsigned FRAC_BITS = 16;

endpackage

>>> rtl/core/crls_ram.sv
// Generic single-port-write, single-port-read RAM with registered read.
module crls_ram #(
    parameter int unsigned WIDTH = 16,
    parameter int unsigned DEPTH = 20
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

>>> rtl/core/cramer_linear_solver_unit.sv
// Top level of the Cramer's rule linear system solver.
// Usage:
//   Load one n-by-n system as n*(n+1) coefficients on the input channel
//   (in_valid/in_ready), row-major, the last of each row the right-hand side.
//   n comes from the system_size register on the APB port (reset value 4);
//   writing it drops a partly loaded system.
//   During loading one item is taken per cycle. After the last coefficient
//   the block stops taking items and works from the coefficient RAM: each
//   determinant walks n^n index tuples and, for each of the n! permutations,
//   does n reads plus n bit-serial multiplies and one accumulate step. Each
//   quotient is computed by restoring division.
//   Results leave on out_valid/out_ready: n Q16.16 solutions, or one
//   no_solution result when the main determinant is zero; last_result marks
//   the final one. A stalled receiver holds the output register and the
//   sequencer waits before the next result; loading of the next system may
//   begin while the final result still waits.
//   Reset empties the output register, clears the load count and sets
//   system_size to 4. The coefficient RAM needs no clearing.
module cramer_linear_solver_unit #(
    parameter int unsigned MAX_SIZE   = 4,
    parameter int unsigned COEF_WIDTH = 16
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [1:0]                   paddr,
    input  logic [31:0]                  pwdata,
    output logic [31:0]                  prdata,
    output logic                         pready,
    input  logic                         in_valid,
    output logic                         in_ready,
    input  logic signed [COEF_WIDTH-1:0] coefficient,
    output logic                         out_valid,
    input  logic                         out_ready,
    output logic signed [31:0]           solution,
    output logic [1:0]                   variable_index,
    output logic                         no_solution,
    output logic                         saturated,
    output logic                         last_result
);

    `include "cramer_linear_solver_unit_defines.svh"

    localparam int unsigned DEPTH = MAX_SIZE * (MAX_SIZE + 1);
    localparam int unsigned AW    = $clog2(DEPTH);
    localparam int unsigned LCW   = $clog2(DEPTH + 1);
    localparam int unsigned NW    = $clog2(MAX_SIZE + 1);
    localparam int unsigned IW    = (MAX_SIZE > 1) ? $clog2(MAX_SIZE) : 1;
    localparam int unsigned DW    = MAX_SIZE * COEF_WIDTH + 16;
    localparam int unsigned QW    = DW + crls_pkg::FRAC_BITS;
    localparam int unsigned BW    = $clog2(COEF_WIDTH);
    localparam int unsigned DCW   = $clog2(QW + 1);

    crls_pkg::state_t state_reg, state_next;

    logic [2:0]               size_reg;
    logic [LCW-1:0]           load_count_reg;
    logic [IW-1:0]            dig_reg [MAX_SIZE];
    logic [IW-1:0]            dig_next [MAX_SIZE];
    logic [IW-1:0]            row_reg, row_next;
    logic [IW-1:0]            col_reg, col_next;
    logic                     main_reg, main_next;
    logic signed [DW-1:0]     acc_reg, acc_next;
    logic signed [DW-1:0]     det_main_reg, det_main_next;
    logic signed [DW-1:0]     p_reg, p_next;
    logic signed [DW-1:0]     msrc_reg, msrc_next;
    logic [COEF_WIDTH-1:0]    mag_reg, mag_next;
    logic [BW-1:0]            bit_reg, bit_next;
    logic [QW-1:0]            qd_reg, qd_next;
    logic [DW:0]              rem_reg, rem_next;
    logic [DW-1:0]            den_reg, den_next;
    logic                     neg_reg, neg_next;
    logic [DCW-1:0]           dcnt_reg, dcnt_next;

    logic                     out_valid_reg;
    logic signed [31:0]       solution_reg;
    logic [1:0]               index_reg;
    logic                     nosol_reg;
    logic                     sat_reg;
    logic                     last_reg;

    logic [NW-1:0]            n_eff;
    logic [LCW-1:0]           total;
    logic                     cfg_wr;
    logic                     in_fire;
    logic                     final_item;
    logic                     slot_free;
    logic                     perm_ok;
    logic                     parity;
    logic                     wrap;
    logic [IW-1:0]            dig_inc [MAX_SIZE];
    logic [NW-1:0]            cm;
    logic [AW-1:0]            rd_addr;
    logic [COEF_WIDTH-1:0]    rd_data;
    logic signed [COEF_WIDTH-1:0] coef_s;
    logic signed [DW-1:0]     mul_sum;
    logic [DW:0]              rem_sh;
    logic                     q_bit;
    logic [DW-1:0]            acc_mag;
    logic [DW-1:0]            det_mag;
    logic [QW-1:0]            lim;
    logic                     sat_c;
    logic [31:0]              mag32;
    logic signed [31:0]       sol_c;
    logic                     col_last;
    logic                     row_last;

    always_comb
    begin
        if (size_reg == 3'd0)
        begin
            n_eff = NW'(1);
        end
        else if (32'(size_reg) > MAX_SIZE)
        begin
            n_eff = NW'(MAX_SIZE);
        end
        else
        begin
            n_eff = NW'(size_reg);
        end
    end

    assign total      = LCW'(LCW'(n_eff) * (LCW'(n_eff) + LCW'(1)));
    assign cfg_wr     = psel && penable && pwrite;
    assign pready     = 1'b1;
    assign prdata     = {29'd0, size_reg};
    assign in_fire    = in_valid && in_ready;
    assign final_item = (load_count_reg + LCW'(1)) == total;
    assign slot_free  = !out_valid_reg || out_ready;
    assign col_last   = NW'(col_reg) == (n_eff - NW'(1));
    assign row_last   = NW'(row_reg) == (n_eff - NW'(1));

    // permutation test and sign of the current index tuple
    always_comb
    begin
        perm_ok = 1'b1;
        parity  = 1'b0;
        for (int i = 0; i < MAX_SIZE; i++)
        begin
            for (int j = 0; j < MAX_SIZE; j++)
            begin
                if ((i < j) && (j < int'(n_eff)))
                begin
                    if (dig_reg[i] == dig_reg[j])
                    begin
                        perm_ok = 1'b0;
                    end
                    if (dig_reg[i] > dig_reg[j])
                    begin
                        parity = ~parity;
                    end
                end
            end
        end
    end

    // advance the index tuple
    always_comb
    begin
        wrap = 1'b1;
        for (int i = 0; i < MAX_SIZE; i++)
        begin
            dig_inc[i] = dig_reg[i];
            if ((i < int'(n_eff)) && wrap)
            begin
                if (NW'(dig_reg[i]) == (n_eff - NW'(1)))
                begin
                    dig_inc[i] = '0;
                end
                else
                begin
                    dig_inc[i] = IW'(dig_reg[i] + 1'b1);
                    wrap       = 1'b0;
                end
            end
        end
    end

    assign cm      = (!main_reg && (col_reg == dig_reg[row_reg])) ? n_eff
                                                                  : NW'(dig_reg[row_reg]);
    assign rd_addr = AW'(LCW'(row_reg) * (LCW'(n_eff) + LCW'(1)) + LCW'(cm));
    assign coef_s  = signed'(rd_data);
    assign mul_sum = (p_reg <<< 1) + (mag_reg[bit_reg] ? msrc_reg : '0);
    assign rem_sh  = {rem_reg[DW-1:0], qd_reg[QW-1]};
    assign q_bit   = rem_sh >= {1'b0, den_reg};
    assign acc_mag = acc_reg[DW-1] ? DW'(-acc_reg) : DW'(acc_reg);
    assign det_mag = det_main_reg[DW-1] ? DW'(-det_main_reg) : DW'(det_main_reg);
    assign lim     = neg_reg ? QW'(64'h8000_0000) : QW'(64'h7FFF_FFFF);
    assign sat_c   = qd_reg > lim;
    assign mag32   = sat_c ? lim[31:0] : qd_reg[31:0];
    assign sol_c   = neg_reg ? signed'(32'(-mag32)) : signed'(mag32);

    crls_ram #(
        .WIDTH(COEF_WIDTH),
        .DEPTH(DEPTH)
    ) u_store (
        .clk  (clk),
        .we   (in_fire),
        .waddr(load_count_reg[AW-1:0]),
        .wdata(coefficient),
        .raddr(rd_addr),
        .rdata(rd_data)
    );

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            crls_pkg::S_LOAD:
            begin
                if (in_fire && final_item)
                begin
                    state_next = crls_pkg::S_TUP;
                end
            end
            crls_pkg::S_TUP:
            begin
                if (perm_ok)
                begin
                    state_next = crls_pkg::S_RD;
                end
                else if (wrap)
                begin
                    state_next = crls_pkg::S_DET_END;
                end
            end
            crls_pkg::S_RD:
            begin
                state_next = crls_pkg::S_OP;
            end
            crls_pkg::S_OP:
            begin
                state_next = crls_pkg::S_MUL;
            end
            crls_pkg::S_MUL:
            begin
                if (bit_reg == '0)
                begin
                    state_next = row_last ? crls_pkg::S_ACC : crls_pkg::S_RD;
                end
            end
            crls_pkg::S_ACC:
            begin
                state_next = wrap ? crls_pkg::S_DET_END : crls_pkg::S_TUP;
            end
            crls_pkg::S_DET_END:
            begin
                if (!main_reg)
                begin
                    state_next = crls_pkg::S_DIV;
                end
                else if (acc_reg == '0)
                begin
                    state_next = crls_pkg::S_NOSOL;
                end
                else
                begin
                    state_next = crls_pkg::S_TUP;
                end
            end
            crls_pkg::S_DIV:
            begin
                if (dcnt_reg == DCW'(1))
                begin
                    state_next = crls_pkg::S_EMIT;
                end
            end
            crls_pkg::S_EMIT:
            begin
                if (slot_free)
                begin
                    state_next = col_last ? crls_pkg::S_LOAD : crls_pkg::S_TUP;
                end
            end
            crls_pkg::S_NOSOL:
            begin
                if (slot_free)
                begin
                    state_next = crls_pkg::S_LOAD;
                end
            end
            default:
            begin
                state_next = crls_pkg::S_LOAD;
            end
        endcase
    end

    // datapath
    always_comb
    begin
        in_ready      = state_reg == crls_pkg::S_LOAD;
        dig_next      = dig_reg;
        row_next      = row_reg;
        col_next      = col_reg;
        main_next     = main_reg;
        acc_next      = acc_reg;
        det_main_next = det_main_reg;
        p_next        = p_reg;
        msrc_next     = msrc_reg;
        mag_next      = mag_reg;
        bit_next      = bit_reg;
        qd_next       = qd_reg;
        rem_next      = rem_reg;
        den_next      = den_reg;
        neg_next      = neg_reg;
        dcnt_next     = dcnt_reg;
        case (state_reg)
            crls_pkg::S_LOAD:
            begin
                main_next = 1'b1;
                col_next  = '0;
                acc_next  = '0;
                for (int i = 0; i < MAX_SIZE; i++)
                begin
                    dig_next[i] = '0;
                end
            end
            crls_pkg::S_TUP:
            begin
                row_next = '0;
                p_next   = DW'(1);
                if (!perm_ok)
                begin
                    dig_next = dig_inc;
                end
            end
            crls_pkg::S_OP:
            begin
                mag_next  = coef_s[COEF_WIDTH-1] ? COEF_WIDTH'(-coef_s)
                                                 : COEF_WIDTH'(coef_s);
                msrc_next = coef_s[COEF_WIDTH-1] ? -p_reg : p_reg;
                p_next    = '0;
                bit_next  = BW'(COEF_WIDTH - 1);
            end
            crls_pkg::S_MUL:
            begin
                p_next   = mul_sum;
                bit_next = bit_reg - BW'(1);
                if ((bit_reg == '0) && !row_last)
                begin
                    row_next = IW'(row_reg + 1'b1);
                end
            end
            crls_pkg::S_ACC:
            begin
                acc_next = parity ? acc_reg - p_reg : acc_reg + p_reg;
                dig_next = dig_inc;
            end
            crls_pkg::S_DET_END:
            begin
                if (main_reg)
                begin
                    det_main_next = acc_reg;
                    main_next     = 1'b0;
                    col_next      = '0;
                    acc_next      = '0;
                end
                else
                begin
                    neg_next  = acc_reg[DW-1] ^ det_main_reg[DW-1];
                    qd_next   = {acc_mag, {crls_pkg::FRAC_BITS{1'b0}}};
                    rem_next  = '0;
                    den_next  = det_mag;
                    dcnt_next = DCW'(QW);
                end
            end
            crls_pkg::S_DIV:
            begin
                rem_next  = q_bit ? rem_sh - {1'b0, den_reg} : rem_sh;
                qd_next   = {qd_reg[QW-2:0], q_bit};
                dcnt_next = dcnt_reg - DCW'(1);
            end
            crls_pkg::S_EMIT:
            begin
                if (slot_free && !col_last)
                begin
                    col_next = IW'(col_reg + 1'b1);
                    acc_next = '0;
                    for (int i = 0; i < MAX_SIZE; i++)
                    begin
                        dig_next[i] = '0;
                    end
                end
            end
            default:
            begin
                acc_next = acc_reg;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= crls_pkg::S_LOAD;
            size_reg       <= 3'd4;
            load_count_reg <= '0;
            main_reg       <= 1'b1;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            main_reg  <= main_next;
            if (cfg_wr)
            begin
                size_reg       <= pwdata[2:0];
                load_count_reg <= '0;
            end
            else if (in_fire)
            begin
                load_count_reg <= final_item ? '0 : LCW'(load_count_reg + 1'b1);
            end
            if ((state_reg == crls_pkg::S_EMIT || state_reg == crls_pkg::S_NOSOL)
                && slot_free)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        dig_reg      <= dig_next;
        row_reg      <= row_next;
        col_reg      <= col_next;
        acc_reg      <= acc_next;
        det_main_reg <= det_main_next;
        p_reg        <= p_next;
        msrc_reg     <= msrc_next;
        mag_reg      <= mag_next;
        bit_reg      <= bit_next;
        qd_reg       <= qd_next;
        rem_reg      <= rem_next;
        den_reg      <= den_next;
        neg_reg      <= neg_next;
        dcnt_reg     <= dcnt_next;
        if (slot_free)
        begin
            if (state_reg == crls_pkg::S_EMIT)
            begin
                solution_reg <= sol_c;
                index_reg    <= 2'(col_reg);
                nosol_reg    <= 1'b0;
                sat_reg      <= sat_c;
                last_reg     <= col_last;
            end
            else if (state_reg == crls_pkg::S_NOSOL)
            begin
                solution_reg <= '0;
                index_reg    <= '0;
                nosol_reg    <= 1'b1;
                sat_reg      <= 1'b0;
                last_reg     <= 1'b1;
            end
        end
    end

    assign out_valid      = out_valid_reg;
    assign solution       = solution_reg;
    assign variable_index = index_reg;
    assign no_solution    = nosol_reg;
    assign saturated      = sat_reg;
    assign last_result    = last_reg;

    `CRLS_ASSERT_NOW(a_no_load_while_busy, clk, rst_n,
        state_reg != crls_pkg::S_LOAD, !in_ready)
    `CRLS_ASSERT_NOW(a_nosol_is_last, clk, rst_n, out_valid_reg && nosol_reg, last_reg)
    `CRLS_ASSERT_NEXT(a_emit_waits, clk, rst_n,
        state_reg == crls_pkg::S_EMIT && out_valid_reg && !out_ready,
        state_reg == crls_pkg::S_EMIT)

endmodule
